// File: src/oldq_pkg.sv
package oldq_pkg;

  // Fixed field widths of the request and result beats
  localparam int ActionW = 2;
  localparam int ItemW   = 32;
  localparam int StatusW = 2;

  typedef enum logic [ActionW-1:0] {
    ACT_FRONT  = 2'd0,
    ACT_BACK   = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  // Per-cell control: request decode shared by all cells, plus position flags
  typedef struct packed {
    logic do_front;   // accepted front insert, list not full
    logic do_back;    // accepted back insert, list not full
    logic do_remove;  // accepted remove
    logic occupied;   // this cell lies below the entry count
    logic tail;       // this cell is the first free slot
  } cell_ctrl_t;

endpackage

// File: src/oldq_cell.sv
module oldq_cell
  import oldq_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [DATA_WIDTH-1:0] value_i,   // request value
  input  logic [DATA_WIDTH-1:0] left_i,    // entry of the cell toward the front
  input  logic [DATA_WIDTH-1:0] right_i,   // entry of the cell toward the back
  input  logic                  found_i,   // a match sits in front of this cell
  output logic                  found_o,   // a match sits here or in front
  output logic [DATA_WIDTH-1:0] entry_o
);

  logic [DATA_WIDTH-1:0] entry_q, entry_d;
  logic                  hit;

  // Match only on a held entry; pass the first-match mark down the row
  assign hit     = ctrl_i.occupied && (entry_q == value_i);
  assign found_o = found_i | hit;

  // Shift back on front insert, load at tail on back insert, pull forward past a match
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.do_front) begin
      entry_d = left_i;
    end else if (ctrl_i.do_back && ctrl_i.tail) begin
      entry_d = value_i;
    end else if (ctrl_i.do_remove && found_o) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: src/ordered_list_deque_remove.sv
// Bounded ordered list of up to CAPACITY values, held in a row of cells from
// front (cell 0) to back. A request beat inserts at the front, inserts at the
// back, removes the first entry equal to the given value (later entries move
// one place forward), or clears the list; each request gives one result beat
// with a status (ok, full with the insert dropped, or not found) and the entry
// count afterwards. Every cell compares and shifts in the same cycle, so one
// request is taken per cycle while the result register is free or being
// drained. The first-match mark ripples through the row of cells, which sets
// the clock period for large CAPACITY.
module ordered_list_deque_remove
  import oldq_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  localparam int CntW      = $clog2(CAPACITY + 1),
  localparam int InPackW   = ActionW + ItemW,
  localparam int InTdataW  = ((InPackW + 7) / 8) * 8,
  localparam int OutPackW  = StatusW + CntW,
  localparam int OutTdataW = ((OutPackW + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InTdataW-1:0]  s_axis_tdata_i,   // action, item_value
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutTdataW-1:0] m_axis_tdata_o    // status, entry_count
);

  logic                  accept;
  action_e               action;
  logic [ItemW-1:0]      item_value;
  logic [DATA_WIDTH-1:0] value;
  logic                  full;
  logic                  found_any;

  logic [CntW-1:0]       count_q, count_d;
  logic                  out_valid_q, out_valid_d;
  status_e               status_q, status_d;
  logic [CntW-1:0]       res_count_q, res_count_d;

  logic [DATA_WIDTH-1:0] entries [CAPACITY];
  logic [CAPACITY:0]     found_chain;

  // Unpack request beat
  assign action     = action_e'(s_axis_tdata_i[ActionW-1:0]);
  assign item_value = s_axis_tdata_i[ActionW +: ItemW];

  generate
    if (DATA_WIDTH >= ItemW) begin : g_value_wide
      assign value = DATA_WIDTH'(item_value);
    end else begin : g_value_narrow
      assign value = item_value[DATA_WIDTH-1:0];
    end
  endgenerate

  // Take a new beat when the result slot is empty or draining
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (count_q == CntW'(CAPACITY));

  // Row of cells
  assign found_chain[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctrl_t            ctrl;
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;

    assign ctrl.do_front  = accept && (action == ACT_FRONT) && !full;
    assign ctrl.do_back   = accept && (action == ACT_BACK) && !full;
    assign ctrl.do_remove = accept && (action == ACT_REMOVE);
    assign ctrl.occupied  = (CntW'(i) < count_q);
    assign ctrl.tail      = (CntW'(i) == count_q);

    if (i == 0) begin : g_head
      assign left = value;
    end else begin : g_body
      assign left = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = entries[i];
    end else begin : g_inner
      assign right = entries[i+1];
    end

    oldq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .value_i(value),
      .left_i (left),
      .right_i(right),
      .found_i(found_chain[i]),
      .found_o(found_chain[i+1]),
      .entry_o(entries[i])
    );
  end

  assign found_any = found_chain[CAPACITY];

  // Update count and result slot
  always_comb begin
    count_d     = count_q;
    status_d    = status_q;
    res_count_d = res_count_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (accept) begin
      status_d = ST_OK;
      case (action)
        ACT_FRONT, ACT_BACK: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
        ACT_REMOVE: begin
          if (found_any) begin
            count_d = count_q - CntW'(1);
          end else begin
            status_d = ST_MISSING;
          end
        end
        default: begin
          count_d = '0;
        end
      endcase
      res_count_d = count_d;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: no reset
  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    res_count_q <= res_count_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutTdataW'({res_count_q, status_q});

endmodule

// File: sim/oldq_checker.sv
// Watch the request and result channels of the ordered list, keep a shadow
// copy of the list, and compare every result beat with the predicted one.
module oldq_checker
  import oldq_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  localparam int CntW      = $clog2(CAPACITY + 1),
  localparam int InPackW   = ActionW + ItemW,
  localparam int InTdataW  = ((InPackW + 7) / 8) * 8,
  localparam int OutPackW  = StatusW + CntW,
  localparam int OutTdataW = ((OutPackW + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  logic                 req_ready_i,
  input  logic [InTdataW-1:0]  req_data_i,    // action, item_value
  input  logic                 rsp_valid_i,
  input  logic                 rsp_ready_i,
  input  logic [OutTdataW-1:0] rsp_data_i,    // status, entry_count
  output int                   fail_cnt_o,
  output int                   pending_o
);

  typedef struct packed {
    status_e         status;
    logic [CntW-1:0] count;
  } list_result_t;

  logic [DATA_WIDTH-1:0] shadow_list[$];
  list_result_t          pending_results[$];
  int                    fail_cnt = 0;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = pending_results.size();

  // Apply one request to the shadow list and return the result it gives
  function automatic list_result_t apply_request(action_e act, logic [DATA_WIDTH-1:0] val);
    list_result_t res;
    int           hit;
    res.status = ST_OK;
    hit = -1;
    case (act)
      ACT_FRONT: begin
        if (shadow_list.size() >= CAPACITY) res.status = ST_FULL;
        else shadow_list.push_front(val);
      end
      ACT_BACK: begin
        if (shadow_list.size() >= CAPACITY) res.status = ST_FULL;
        else shadow_list.push_back(val);
      end
      ACT_REMOVE: begin
        // first match from the front only; later entries close the gap
        foreach (shadow_list[i]) if (hit < 0 && shadow_list[i] == val) hit = i;
        if (hit < 0) res.status = ST_MISSING;
        else shadow_list.delete(hit);
      end
      default: begin
        shadow_list = {};
      end
    endcase
    res.count = CntW'(shadow_list.size());
    return res;
  endfunction

  // Count a failure; report only the first few in detail
  function automatic void note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t got;
    list_result_t want;
    if (!rst_ni) begin
      shadow_list     = {};
      pending_results = {};
    end else begin
      // compare the result beat with the oldest prediction
      if (rsp_valid_i && rsp_ready_i) begin
        got.status = status_e'(rsp_data_i[StatusW-1:0]);
        got.count  = rsp_data_i[StatusW +: CntW];
        if (pending_results.size() == 0) begin
          note_failure($sformatf("unexpected result beat: status %0d count %0d",
                                 got.status, got.count));
        end else begin
          want = pending_results.pop_front();
          if (got.status != want.status || got.count != want.count)
            note_failure($sformatf("result mismatch: status exp %0d got %0d, count exp %0d got %0d",
                                   want.status, got.status, want.count, got.count));
        end
      end
      // predict the result of each accepted request beat
      if (req_valid_i && req_ready_i)
        pending_results.push_back(apply_request(action_e'(req_data_i[ActionW-1:0]),
                                                DATA_WIDTH'(req_data_i[ActionW +: ItemW])));
    end
  end

endmodule

// File: sim/tb.sv
module tb;
  import oldq_pkg::*;

  localparam int Capacity  = 16;
  localparam int DataW     = 32;
  localparam int CntW      = $clog2(Capacity + 1);
  localparam int InPackW   = ActionW + ItemW;
  localparam int InTdataW  = ((InPackW + 7) / 8) * 8;
  localparam int OutTdataW = ((StatusW + CntW + 7) / 8) * 8;
  localparam int ItemsPerPhase = 317;

  logic                 clk_i = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_valid = 1'b0;
  logic [InTdataW-1:0]  s_data = '0;
  logic                 s_ready;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [OutTdataW-1:0] m_data;
  int                   tx_idle_pct = 25;
  int                   rx_idle_pct = 75;
  int                   fail_cnt;
  int                   pending;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ordered_list_deque_remove #(
    .CAPACITY  (Capacity),
    .DATA_WIDTH(DataW)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  oldq_checker #(
    .CAPACITY  (Capacity),
    .DATA_WIDTH(DataW)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .req_valid_i(s_valid),
    .req_ready_i(s_ready),
    .req_data_i (s_data),
    .rsp_valid_i(m_valid),
    .rsp_ready_i(m_ready),
    .rsp_data_i (m_data),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // Stall the result channel at random
  always @(posedge clk_i) begin
    m_ready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Drive one request beat, with random gaps before it
  task automatic send_req(action_e act, logic [ItemW-1:0] val);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {{(InTdataW - InPackW){1'b0}}, val, act};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  // Favor a small pool of values so removals often find a match
  function automatic logic [ItemW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      2, 3:    return $urandom;
      default: return ItemW'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic action_e pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return ACT_FRONT;
    if (r < 60) return ACT_BACK;
    if (r < 96) return ACT_REMOVE;
    return ACT_CLEAR;
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // empty list: clear and remove
    send_req(ACT_CLEAR, 32'h0000_0000);
    send_req(ACT_REMOVE, 32'h0000_0005);
    // extreme values, duplicate removed from the front
    send_req(ACT_FRONT, 32'h0000_0000);
    send_req(ACT_BACK, 32'hFFFF_FFFF);
    send_req(ACT_FRONT, 32'h0000_0000);
    send_req(ACT_REMOVE, 32'h0000_0000);
    send_req(ACT_REMOVE, 32'h0000_0003);
    // fill up, then insert at both ends while full
    for (int k = 0; k < Capacity - 2; k++) send_req(ACT_BACK, 32'h1000 + k);
    send_req(ACT_FRONT, 32'hA5A5_A5A5);
    send_req(ACT_BACK, 32'h5A5A_5A5A);
    // remove the last entry, then one from the middle
    send_req(ACT_REMOVE, 32'h1000 + Capacity - 3);
    send_req(ACT_REMOVE, 32'hFFFF_FFFF);
    send_req(ACT_FRONT, 32'h5555_AAAA);
    send_req(ACT_CLEAR, 32'hFFFF_FFFF);

    // random traffic under three idle patterns
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 75 : 0;
      rx_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 25 : 0;
      repeat (ItemsPerPhase) send_req(pick_action(), pick_value());
    end
    s_valid <= 1'b0;

    // drain outstanding results
    while (pending != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
